// File: sv/kpl_pkg.sv
// ----------------------------------------------------------------------------
// kpl_pkg - shared definitions for the keypad time window lock
// Key codes, status codes, register indexes, field widths and the result
// word layout used by the lock and its checker.
// ----------------------------------------------------------------------------
package kpl_pkg;

  // Password geometry and retry limit.
  localparam int PW_LEN       = 5;
  localparam int MAX_ATTEMPTS = 3;

  // Field widths.
  localparam int KEY_W  = 8;
  localparam int MIN_W  = 11;
  localparam int NIB_W  = 4;
  localparam int PW_W   = PW_LEN * NIB_W;
  localparam int CNT_W  = 3;
  localparam int ATT_W  = 2;
  localparam int STAT_W = 3;
  localparam int IDX_W  = (PW_LEN > 1) ? $clog2(PW_LEN) : 1;

  // Stream and configuration port widths.
  localparam int S_DATA_W = 24;
  localparam int M_DATA_W = 16;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = PW_W;

  // Reset values of the configuration registers.
  localparam logic [PW_W-1:0]  PW_RESET    = 20'h12345;
  localparam logic [MIN_W-1:0] START_RESET = '0;
  localparam logic [MIN_W-1:0] STOP_RESET  = '0;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_PASSWORD = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_START    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_STOP     = 2'd2;

  // Key codes (ASCII).
  localparam logic [KEY_W-1:0] KEY_0     = 8'h30;
  localparam logic [KEY_W-1:0] KEY_9     = 8'h39;
  localparam logic [KEY_W-1:0] KEY_BACK  = 8'h42;
  localparam logic [KEY_W-1:0] KEY_ENTER = 8'h45;

  // Status codes.
  localparam logic [STAT_W-1:0] ST_IGNORED   = 3'd0;
  localparam logic [STAT_W-1:0] ST_STARTED   = 3'd1;
  localparam logic [STAT_W-1:0] ST_DIGIT     = 3'd2;
  localparam logic [STAT_W-1:0] ST_REMOVED   = 3'd3;
  localparam logic [STAT_W-1:0] ST_RETRY     = 3'd4;
  localparam logic [STAT_W-1:0] ST_EXHAUSTED = 3'd5;
  localparam logic [STAT_W-1:0] ST_GRANTED   = 3'd6;
  localparam logic [STAT_W-1:0] ST_OUTSIDE   = 3'd7;

  // One result word; status sits in the lowest bits.
  typedef struct packed {
    logic              session_open;
    logic [ATT_W-1:0]  attempts_used;
    logic [CNT_W-1:0]  digits_entered;
    logic [STAT_W-1:0] status;
  } result_t;

  localparam int RES_W = $bits(result_t);

endpackage

// File: sv/keypad_password_time_window_lock.sv
// ----------------------------------------------------------------------------
// keypad_password_time_window_lock - keypad combination lock with time window
// Takes one key press per word and reports one status word per key.
// ----------------------------------------------------------------------------
// Usage:
//   Input stream (s_axis_*): one word per key press. tdata carries the ASCII
//   key code and the present minute of the day. 'E' opens a session, digits
//   fill the entry buffer, 'B' removes the last digit, other keys are ignored.
//   The fifth digit triggers the password compare; a match grants access
//   only when the minute lies between start and stop, both included.
//   Output stream (m_axis_*): exactly one status word per accepted key, in
//   order, giving the status code, digits held, failed attempts and whether
//   a session is still open.
//   Configuration: cfg_we writes password, start minute or stop minute at
//   cfg_index; write only while no key is in flight.
//   Results are registered in the output register or the skid register. One
//   key is accepted every cycle while s_axis_tready is high; the state update,
//   buffer compare and window check are a single registered step.
//   A skid register behind the output register lets one extra key in while
//   the receiver stalls; s_axis_tready drops only when that is full.
//   Reset (rst, synchronous) closes the session, clears the counts, empties
//   the output side and restores the configuration reset values.
// ----------------------------------------------------------------------------
module keypad_password_time_window_lock (
  input  logic                          clk,
  input  logic                          rst,
  // tdata: key_code[7:0], current_minute[18:8], zero fill above
  input  logic [kpl_pkg::S_DATA_W-1:0]  s_axis_tdata,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  // tdata: status[2:0], digits_entered[5:3], attempts_used[7:6],
  //        session_open[8], zero fill above
  output logic [kpl_pkg::M_DATA_W-1:0]  m_axis_tdata,
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  input  logic                          cfg_we,
  input  logic [kpl_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [kpl_pkg::CFG_DATA_W-1:0] cfg_data
);

  // Configuration registers.
  logic [kpl_pkg::PW_W-1:0]  password;
  logic [kpl_pkg::MIN_W-1:0] start_minute;
  logic [kpl_pkg::MIN_W-1:0] stop_minute;

  // Session state.
  logic                      session_active;
  logic [kpl_pkg::CNT_W-1:0] entry_count;
  logic [kpl_pkg::ATT_W-1:0] failed_attempts;
  logic [kpl_pkg::NIB_W-1:0] entry_buffer [kpl_pkg::PW_LEN];

  logic session_active_next;
  logic [kpl_pkg::CNT_W-1:0] entry_count_next;
  logic [kpl_pkg::ATT_W-1:0] failed_attempts_next;

  // Output side.
  kpl_pkg::result_t result_word;
  kpl_pkg::result_t out_word;
  kpl_pkg::result_t skid_word;
  logic             skid_valid;

  logic                       accept;
  logic                       out_free;
  logic [kpl_pkg::KEY_W-1:0]  key;
  logic [kpl_pkg::MIN_W-1:0]  now;
  logic                       key_numeric;
  logic [kpl_pkg::NIB_W-1:0]  digit;
  logic                       buffer_match;
  logic                       last_digit;
  logic                       in_window;
  logic [kpl_pkg::ATT_W-1:0]  attempts_inc;
  logic [kpl_pkg::STAT_W-1:0] status;

  assign key      = s_axis_tdata[kpl_pkg::KEY_W-1:0];
  assign now      = s_axis_tdata[kpl_pkg::KEY_W +: kpl_pkg::MIN_W];
  assign accept   = s_axis_tvalid && s_axis_tready;
  assign out_free = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = !skid_valid;

  // Key decode.
  assign key_numeric = key inside {[kpl_pkg::KEY_0:kpl_pkg::KEY_9]};
  assign digit    = kpl_pkg::NIB_W'(key - kpl_pkg::KEY_0);
  assign last_digit = (entry_count == kpl_pkg::CNT_W'(kpl_pkg::PW_LEN - 1));
  assign in_window  = (now >= start_minute) && (now <= stop_minute);
  assign attempts_inc = failed_attempts + kpl_pkg::ATT_W'(1);

  // Compare the held digits plus the incoming one with the password.
  always_comb begin
    buffer_match = (digit == password[kpl_pkg::NIB_W-1:0]);
    for (int i = 0; i < kpl_pkg::PW_LEN - 1; i++) begin
      if (entry_buffer[i] !=
          password[kpl_pkg::NIB_W*(kpl_pkg::PW_LEN-1-i) +: kpl_pkg::NIB_W]) begin
        buffer_match = 1'b0;
      end
    end
  end

  // Next session state and status for the key at the input.
  always_comb begin
    session_active_next  = session_active;
    entry_count_next     = entry_count;
    failed_attempts_next = failed_attempts;
    status               = kpl_pkg::ST_IGNORED;
    if (!session_active) begin
      if (key == kpl_pkg::KEY_ENTER) begin
        session_active_next  = 1'b1;
        entry_count_next     = '0;
        failed_attempts_next = '0;
        status               = kpl_pkg::ST_STARTED;
      end
    end else if (key_numeric) begin
      if (last_digit) begin
        entry_count_next = '0;
        if (buffer_match) begin
          session_active_next = 1'b0;
          status = in_window ? kpl_pkg::ST_GRANTED : kpl_pkg::ST_OUTSIDE;
        end else begin
          failed_attempts_next = attempts_inc;
          if (attempts_inc >= kpl_pkg::ATT_W'(kpl_pkg::MAX_ATTEMPTS)) begin
            session_active_next = 1'b0;
            status = kpl_pkg::ST_EXHAUSTED;
          end else begin
            status = kpl_pkg::ST_RETRY;
          end
        end
      end else begin
        entry_count_next = entry_count + kpl_pkg::CNT_W'(1);
        status           = kpl_pkg::ST_DIGIT;
      end
    end else if (key == kpl_pkg::KEY_BACK && entry_count != '0) begin
      entry_count_next = entry_count - kpl_pkg::CNT_W'(1);
      status           = kpl_pkg::ST_REMOVED;
    end
  end

  always_comb begin
    result_word.status         = status;
    result_word.digits_entered = entry_count_next;
    result_word.attempts_used  = failed_attempts_next;
    result_word.session_open   = session_active_next;
  end

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      password     <= kpl_pkg::PW_RESET;
      start_minute <= kpl_pkg::START_RESET;
      stop_minute  <= kpl_pkg::STOP_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        kpl_pkg::REG_PASSWORD: password     <= cfg_data;
        kpl_pkg::REG_START:    start_minute <= cfg_data[kpl_pkg::MIN_W-1:0];
        kpl_pkg::REG_STOP:     stop_minute  <= cfg_data[kpl_pkg::MIN_W-1:0];
        default: ;
      endcase
    end
  end

  // Session state update.
  always_ff @(posedge clk) begin
    if (rst) begin
      session_active  <= 1'b0;
      entry_count     <= '0;
      failed_attempts <= '0;
    end else if (accept) begin
      session_active  <= session_active_next;
      entry_count     <= entry_count_next;
      failed_attempts <= failed_attempts_next;
    end
  end

  // Entry buffer: a digit lands at the current fill position.
  always_ff @(posedge clk) begin
    if (accept && session_active && key_numeric) begin
      entry_buffer[entry_count[kpl_pkg::IDX_W-1:0]] <= digit;
    end
  end

  // Output register with a skid stage behind it.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
      skid_valid    <= 1'b0;
    end else if (!out_free) begin
      if (accept) begin
        skid_valid <= 1'b1;
      end
    end else if (skid_valid) begin
      m_axis_tvalid <= 1'b1;
      skid_valid    <= 1'b0;
    end else begin
      m_axis_tvalid <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_free) begin
      if (accept) begin
        skid_word <= result_word;
      end
    end else if (skid_valid) begin
      out_word <= skid_word;
    end else if (accept) begin
      out_word <= result_word;
    end
  end

  assign m_axis_tdata = {(kpl_pkg::M_DATA_W - kpl_pkg::RES_W)'(0), out_word};

endmodule

// File: sv/kpl_checker.sv
// ----------------------------------------------------------------------------
// kpl_checker - port level checks for the keypad time window lock
// Watches the result stream and checks that the reported fields agree.
// ----------------------------------------------------------------------------
module kpl_checker (
  input logic                         clk,
  input logic                         rst,
  input logic [kpl_pkg::M_DATA_W-1:0] m_axis_tdata,
  input logic                         m_axis_tvalid,
  input logic                         m_axis_tready
);

  kpl_pkg::result_t res;
  assign res = kpl_pkg::result_t'(m_axis_tdata[kpl_pkg::RES_W-1:0]);

  // The output side is empty right after reset.
  a_reset_empty: assert property (@(posedge clk) rst |=> !m_axis_tvalid)
    else $error("result valid right after reset");

  // A stalled result holds its word.
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("stalled result changed");

  // With no session open, the entry buffer is reported empty.
  a_closed_empty: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !res.session_open |-> res.digits_entered == '0)
    else $error("digits reported with no session open");

  // A session that just opened starts with clean counts.
  a_start_clean: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && res.status == kpl_pkg::ST_STARTED |->
      res.session_open && res.digits_entered == '0 && res.attempts_used == '0)
    else $error("session start with stale counts");

  // A finished compare or the last failure closes the session.
  a_end_closes: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && (res.status == kpl_pkg::ST_GRANTED ||
                      res.status == kpl_pkg::ST_OUTSIDE ||
                      res.status == kpl_pkg::ST_EXHAUSTED) |-> !res.session_open)
    else $error("session still open after it ended");

endmodule

bind keypad_password_time_window_lock kpl_checker u_kpl_checker (
  .clk           (clk),
  .rst           (rst),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready)
);

// File: sim/tb_keypad_password_time_window_lock.sv
// ----------------------------------------------------------------------------
// tb_keypad_password_time_window_lock - self-checking bench for the keypad lock
// Sends key words with a minute of day through the input stream and checks
// every status word against a cycle-free model of the lock. A short table of
// directed key sequences comes first, and then random sessions under several
// register settings. Both stream sides idle and stall at random.
// ----------------------------------------------------------------------------
module tb_keypad_password_time_window_lock;
  timeunit 1ns;
  timeprecision 1ps;

  // Key codes that the lock treats as noise, and minute limits.
  localparam logic [kpl_pkg::KEY_W-1:0] KEY_NUL   = 8'h00;
  localparam logic [kpl_pkg::KEY_W-1:0] KEY_ALL   = 8'hFF;
  localparam logic [kpl_pkg::KEY_W-1:0] KEY_COLON = 8'h3A;
  localparam logic [kpl_pkg::MIN_W-1:0] DAY_LAST  = 11'd1439;
  localparam logic [kpl_pkg::MIN_W-1:0] MIN_TOP   = 11'h7FF;

  localparam int PHASES         = 6;
  localparam int WORDS_PER_PHASE = 105;
  localparam int WATCHDOG_LIMIT = 1000;

  // One line of the directed table: a key word or a register load.
  typedef struct packed {
    bit                             is_cfg;
    logic [kpl_pkg::KEY_W-1:0]      key;
    logic [kpl_pkg::MIN_W-1:0]      minute;
    logic [kpl_pkg::PW_W-1:0]       pw;
    logic [kpl_pkg::MIN_W-1:0]      start_m;
    logic [kpl_pkg::MIN_W-1:0]      stop_m;
    bit                             typed;
    kpl_pkg::result_t               want;
  } plan_row_t;

  logic                           clk = 1'b0;
  logic                           rst = 1'b1;
  logic [kpl_pkg::S_DATA_W-1:0]   s_axis_tdata = '0;
  logic                           s_axis_tvalid = 1'b0;
  logic                           s_axis_tready;
  logic [kpl_pkg::M_DATA_W-1:0]   m_axis_tdata;
  logic                           m_axis_tvalid;
  logic                           m_axis_tready = 1'b0;
  logic                           cfg_we = 1'b0;
  logic [kpl_pkg::CFG_IDX_W-1:0]  cfg_index = kpl_pkg::REG_PASSWORD;
  logic [kpl_pkg::CFG_DATA_W-1:0] cfg_data = '0;

  // Lock model state and its copy of the registers.
  bit                        lock_open = 1'b0;
  logic [kpl_pkg::NIB_W-1:0] entry_nib [kpl_pkg::PW_LEN];
  int                        entry_cnt = 0;
  int                        tries_failed = 0;
  logic [kpl_pkg::PW_W-1:0]  pw_cfg = kpl_pkg::PW_RESET;
  logic [kpl_pkg::MIN_W-1:0] start_cfg = kpl_pkg::START_RESET;
  logic [kpl_pkg::MIN_W-1:0] stop_cfg = kpl_pkg::STOP_RESET;

  // Status words still owed by the lock, oldest first.
  kpl_pkg::result_t pending_status [$];
  plan_row_t        plan [$];
  int               bad_words = 0;
  bit               aim_right = 1'b0;
  bit               tx_gaps_on = 1'b1;
  bit               rx_stall_on = 1'b1;
  int               stall_left = 0;

  keypad_password_time_window_lock i_dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Advances the lock model by one key and returns the status word it owes.
  function automatic kpl_pkg::result_t lock_step(input logic [kpl_pkg::KEY_W-1:0] key,
                                                 input logic [kpl_pkg::MIN_W-1:0] minute);
    kpl_pkg::result_t r;
    bit               hit;
    int               i;
    r.status = kpl_pkg::ST_IGNORED;
    if (!lock_open) begin
      if (key == kpl_pkg::KEY_ENTER) begin
        lock_open = 1'b1;
        entry_cnt = 0;
        tries_failed = 0;
        r.status = kpl_pkg::ST_STARTED;
      end
    end else if (key >= kpl_pkg::KEY_0 && key <= kpl_pkg::KEY_9) begin
      entry_nib[entry_cnt] = kpl_pkg::NIB_W'(key - kpl_pkg::KEY_0);
      entry_cnt++;
      r.status = kpl_pkg::ST_DIGIT;
      if (entry_cnt == kpl_pkg::PW_LEN) begin
        entry_cnt = 0;
        // The first digit typed is compared with the top nibble.
        hit = 1'b1;
        for (i = 0; i < kpl_pkg::PW_LEN; i++) begin
          if (entry_nib[i] !=
              pw_cfg[kpl_pkg::NIB_W*(kpl_pkg::PW_LEN-1-i) +: kpl_pkg::NIB_W]) hit = 1'b0;
        end
        if (hit) begin
          lock_open = 1'b0;
          r.status = (minute >= start_cfg && minute <= stop_cfg) ?
                     kpl_pkg::ST_GRANTED : kpl_pkg::ST_OUTSIDE;
        end else begin
          tries_failed++;
          if (tries_failed >= kpl_pkg::MAX_ATTEMPTS) begin
            lock_open = 1'b0;
            r.status = kpl_pkg::ST_EXHAUSTED;
          end else begin
            r.status = kpl_pkg::ST_RETRY;
          end
        end
      end
    end else if (key == kpl_pkg::KEY_BACK && entry_cnt > 0) begin
      entry_cnt--;
      r.status = kpl_pkg::ST_REMOVED;
    end
    r.digits_entered = kpl_pkg::CNT_W'(entry_cnt);
    r.attempts_used = kpl_pkg::ATT_W'(tries_failed);
    r.session_open = lock_open;
    return r;
  endfunction

  // Mostly short pauses, now and then a long one.
  function automatic int pause_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return $urandom_range(1, 3);
    if (r < 93) return $urandom_range(4, 10);
    return $urandom_range(20, 40);
  endfunction

  // Keys follow real sessions most of the time: enter, then digits that
  // either aim at the password or are random, with some backspace and noise.
  function automatic logic [kpl_pkg::KEY_W-1:0] pick_key();
    int r;
    int nib;
    r = $urandom_range(0, 99);
    if (!lock_open) begin
      return (r < 75) ? kpl_pkg::KEY_ENTER : kpl_pkg::KEY_W'($urandom_range(0, 255));
    end
    if (r < 6) return kpl_pkg::KEY_W'($urandom_range(0, 255));
    if (r < 14) return kpl_pkg::KEY_BACK;
    if (r < 17) return kpl_pkg::KEY_ENTER;
    if (entry_cnt == 0) aim_right = ($urandom_range(0, 1) == 1);
    nib = pw_cfg[kpl_pkg::NIB_W*(kpl_pkg::PW_LEN-1-entry_cnt) +: kpl_pkg::NIB_W];
    if (!aim_right || nib > 9) nib = $urandom_range(0, 9);
    return kpl_pkg::KEY_0 + kpl_pkg::KEY_W'(nib);
  endfunction

  // Minutes cluster on the window bounds, just outside them and inside the window.
  function automatic logic [kpl_pkg::MIN_W-1:0] pick_minute();
    case ($urandom_range(0, 9))
      0: return kpl_pkg::MIN_W'($urandom_range(0, 2047));
      1: return start_cfg;
      2: return stop_cfg;
      3: return start_cfg - 1'b1;
      4: return stop_cfg + 1'b1;
      default: begin
        if (start_cfg <= stop_cfg) begin
          return kpl_pkg::MIN_W'($urandom_range(stop_cfg, start_cfg));
        end
        return kpl_pkg::MIN_W'($urandom_range(0, DAY_LAST));
      end
    endcase
  endfunction

  function automatic plan_row_t press(input logic [kpl_pkg::KEY_W-1:0] key,
                                      input logic [kpl_pkg::MIN_W-1:0] minute);
    plan_row_t p;
    p = '0;
    p.key = key;
    p.minute = minute;
    return p;
  endfunction

  function automatic plan_row_t press_want(input logic [kpl_pkg::KEY_W-1:0] key,
                                           input logic [kpl_pkg::MIN_W-1:0] minute,
                                           input logic [kpl_pkg::STAT_W-1:0] st,
                                           input int cnt, input int att,
                                           input bit open);
    plan_row_t p;
    p = press(key, minute);
    p.typed = 1'b1;
    p.want.status = st;
    p.want.digits_entered = kpl_pkg::CNT_W'(cnt);
    p.want.attempts_used = kpl_pkg::ATT_W'(att);
    p.want.session_open = open;
    return p;
  endfunction

  function automatic plan_row_t regs(input logic [kpl_pkg::PW_W-1:0] pw,
                                     input logic [kpl_pkg::MIN_W-1:0] st,
                                     input logic [kpl_pkg::MIN_W-1:0] sp);
    plan_row_t p;
    p = '0;
    p.is_cfg = 1'b1;
    p.pw = pw;
    p.start_m = st;
    p.stop_m = sp;
    return p;
  endfunction

  // Sends one key word and records the status word it must produce.
  task automatic send_key(input logic [kpl_pkg::KEY_W-1:0] key,
                          input logic [kpl_pkg::MIN_W-1:0] minute,
                          input bit typed, input kpl_pkg::result_t want);
    kpl_pkg::result_t predicted;
    int               gap;
    s_axis_tdata <= kpl_pkg::S_DATA_W'({minute, key});
    s_axis_tvalid <= 1'b1;
    do @(posedge clk); while (!s_axis_tready);
    predicted = lock_step(key, minute);
    pending_status.push_back(typed ? want : predicted);
    gap = (tx_gaps_on && $urandom_range(0, 99) < 40) ? pause_len() : 0;
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Holds the sender back until every owed status word has come out.
  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    while (pending_status.size() != 0) @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  // Loads all three registers back to back while the lock is idle.
  task automatic load_regs(input logic [kpl_pkg::PW_W-1:0] pw,
                           input logic [kpl_pkg::MIN_W-1:0] st,
                           input logic [kpl_pkg::MIN_W-1:0] sp);
    wait_drained();
    cfg_we <= 1'b1;
    cfg_index <= kpl_pkg::REG_PASSWORD;
    cfg_data <= pw;
    @(posedge clk);
    cfg_index <= kpl_pkg::REG_START;
    cfg_data <= kpl_pkg::CFG_DATA_W'(st);
    @(posedge clk);
    cfg_index <= kpl_pkg::REG_STOP;
    cfg_data <= kpl_pkg::CFG_DATA_W'(sp);
    @(posedge clk);
    cfg_we <= 1'b0;
    pw_cfg = pw;
    start_cfg = st;
    stop_cfg = sp;
  endtask

  // Receiver: checks each status word and stalls at random.
  always @(posedge clk) begin : status_check
    kpl_pkg::result_t got;
    kpl_pkg::result_t want;
    if (rst) begin
      m_axis_tready <= 1'b0;
      stall_left <= 0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        got = kpl_pkg::result_t'(m_axis_tdata[kpl_pkg::RES_W-1:0]);
        if (pending_status.size() == 0) begin
          bad_words++;
          if (bad_words <= 10) $display("unexpected status word %h", m_axis_tdata);
        end else begin
          want = pending_status.pop_front();
          if (got != want || m_axis_tdata[kpl_pkg::M_DATA_W-1:kpl_pkg::RES_W] != '0) begin
            bad_words++;
            if (bad_words <= 10) begin
              $display("status word mismatch: want st=%0d cnt=%0d att=%0d open=%0d",
                       want.status, want.digits_entered, want.attempts_used,
                       want.session_open);
              $display("                       got st=%0d cnt=%0d att=%0d open=%0d fill=%h",
                       got.status, got.digits_entered, got.attempts_used,
                       got.session_open,
                       m_axis_tdata[kpl_pkg::M_DATA_W-1:kpl_pkg::RES_W]);
            end
          end
        end
      end
      if (stall_left > 0) begin
        stall_left <= stall_left - 1;
        m_axis_tready <= 1'b0;
      end else if (rx_stall_on && $urandom_range(0, 99) < 20) begin
        stall_left <= pause_len() - 1;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  // Ends the run when neither side has moved a word for too long.
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) quiet = 0;
      else quiet++;
    end
    $display("tb_keypad_password_time_window_lock: done, errors");
    $finish;
  end

  initial begin : stimulus
    int                        ph;
    int                        n;
    int                        k;
    logic [kpl_pkg::PW_W-1:0]  pw;
    logic [kpl_pkg::MIN_W-1:0] st;
    logic [kpl_pkg::MIN_W-1:0] sp;

    for (k = 0; k < kpl_pkg::PW_LEN; k++) entry_nib[k] = '0;

    // Directed sequences, starting from the reset registers.
    plan.push_back(press_want(KEY_NUL, 11'd0, kpl_pkg::ST_IGNORED, 0, 0, 1'b0));
    plan.push_back(press_want(KEY_ALL, MIN_TOP, kpl_pkg::ST_IGNORED, 0, 0, 1'b0));
    plan.push_back(press_want(kpl_pkg::KEY_BACK, 11'd0, kpl_pkg::ST_IGNORED, 0, 0, 1'b0));
    plan.push_back(press_want(kpl_pkg::KEY_ENTER, 11'd0, kpl_pkg::ST_STARTED, 0, 0, 1'b1));
    plan.push_back(press_want(kpl_pkg::KEY_ENTER, 11'd0, kpl_pkg::ST_IGNORED, 0, 0, 1'b1));
    plan.push_back(press_want(kpl_pkg::KEY_BACK, 11'd0, kpl_pkg::ST_IGNORED, 0, 0, 1'b1));
    plan.push_back(press_want(kpl_pkg::KEY_0 + 8'd1, 11'd0, kpl_pkg::ST_DIGIT, 1, 0, 1'b1));
    plan.push_back(press_want(kpl_pkg::KEY_BACK, 11'd0, kpl_pkg::ST_REMOVED, 0, 0, 1'b1));
    plan.push_back(press_want(KEY_COLON, 11'd0, kpl_pkg::ST_IGNORED, 0, 0, 1'b1));
    plan.push_back(press(kpl_pkg::KEY_0 + 8'd1, 11'd0));
    plan.push_back(press(kpl_pkg::KEY_0 + 8'd2, 11'd0));
    plan.push_back(press(kpl_pkg::KEY_0 + 8'd3, 11'd0));
    plan.push_back(press(kpl_pkg::KEY_0 + 8'd4, 11'd0));
    plan.push_back(press_want(kpl_pkg::KEY_0 + 8'd5, 11'd0, kpl_pkg::ST_GRANTED, 0, 0, 1'b0));
    // A nibble above nine in the password can never be matched.
    plan.push_back(regs(20'h1234F, 11'd0, DAY_LAST));
    plan.push_back(press_want(kpl_pkg::KEY_ENTER, 11'd0, kpl_pkg::ST_STARTED, 0, 0, 1'b1));
    plan.push_back(press(kpl_pkg::KEY_0 + 8'd1, 11'd100));
    plan.push_back(press(kpl_pkg::KEY_0 + 8'd2, 11'd100));
    plan.push_back(press(kpl_pkg::KEY_0 + 8'd3, 11'd100));
    plan.push_back(press(kpl_pkg::KEY_0 + 8'd4, 11'd100));
    plan.push_back(press_want(kpl_pkg::KEY_9, MIN_TOP, kpl_pkg::ST_RETRY, 0, 1, 1'b1));
    // Start after stop leaves an empty window.
    plan.push_back(regs(20'h00000, DAY_LAST, 11'd0));
    plan.push_back(press_want(kpl_pkg::KEY_ENTER, 11'd700, kpl_pkg::ST_IGNORED, 0, 1, 1'b1));
    for (k = 0; k < 4; k++) plan.push_back(press(kpl_pkg::KEY_0, 11'd700));
    plan.push_back(press_want(kpl_pkg::KEY_0, 11'd700, kpl_pkg::ST_OUTSIDE, 0, 1, 1'b0));

    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    for (n = 0; n < plan.size(); n++) begin
      if (plan[n].is_cfg) load_regs(plan[n].pw, plan[n].start_m, plan[n].stop_m);
      else send_key(plan[n].key, plan[n].minute, plan[n].typed, plan[n].want);
    end

    // Random sessions under a series of register settings.
    for (ph = 0; ph < PHASES; ph++) begin
      pw = '0;
      for (k = 0; k < kpl_pkg::PW_LEN; k++) begin
        pw[kpl_pkg::NIB_W*k +: kpl_pkg::NIB_W] = kpl_pkg::NIB_W'($urandom_range(0, 9));
      end
      st = kpl_pkg::MIN_W'($urandom_range(0, DAY_LAST));
      sp = kpl_pkg::MIN_W'($urandom_range(DAY_LAST, st));
      case (ph)
        0: begin
          pw = kpl_pkg::PW_RESET;
          st = '0;
          sp = DAY_LAST;
        end
        1: begin
          pw = '0;
          st = '0;
          sp = '0;
        end
        2: begin
          pw = 20'h99999;
          st = DAY_LAST;
          sp = DAY_LAST;
        end
        4: begin
          pw = kpl_pkg::PW_W'($urandom_range(0, 20'h99999));
          sp = kpl_pkg::MIN_W'($urandom_range(0, DAY_LAST));
        end
        5: begin
          st = 11'd600;
          sp = 11'd1200;
        end
        default: ;
      endcase
      load_regs(pw, st, sp);
      tx_gaps_on = (ph != 1) && (ph != 5);
      rx_stall_on = (ph != 1) && (ph != 3);
      for (n = 0; n < WORDS_PER_PHASE; n++) send_key(pick_key(), pick_minute(), 1'b0, '0);
    end

    wait_drained();
    repeat (10) @(posedge clk);
    if (bad_words == 0 && pending_status.size() == 0) begin
      $display("tb_keypad_password_time_window_lock: done, clean");
    end else begin
      $display("tb_keypad_password_time_window_lock: done, errors");
    end
    $finish;
  end

endmodule

// File: keypad_password_time_window_lock.f
sv/kpl_pkg.sv
sv/keypad_password_time_window_lock.sv
sv/kpl_checker.sv
sim/tb_keypad_password_time_window_lock.sv
